// File: rtl/lpg_pkg.sv
// shared types and constants for the line point generator
package lpg_pkg;

    localparam int COLOR_BITS = 16;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // per-axis step code, read as a 2-bit signed increment
    typedef enum logic [1:0]
    {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } step_dir_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } ctrl_state_t;

    typedef struct packed
    {
        logic load;
        logic advance;
    } lpg_cmd_t;

    typedef struct packed
    {
        logic last;
    } lpg_status_t;

endpackage

// File: rtl/lpg_if.sv
// valid/ready channel interfaces for line commands and emitted pixels
interface lpg_cmd_if #(
    parameter int COORD_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;
    logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;

    modport source (output valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                    input ready);
    modport sink   (input valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                    output ready);
endinterface

interface lpg_pixel_if #(
    parameter int COORD_BITS = 10
);
    logic                          valid;
    logic                          ready;
    logic [COORD_BITS-1:0]         point_x;
    logic [COORD_BITS-1:0]         point_y;
    logic [lpg_pkg::COLOR_BITS-1:0] point_color;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_color, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_color, last_point, output ready);
endinterface

// File: rtl/lpg_ctrl.sv
// line controller: active state, handshakes and output valid
module lpg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_op,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lpg_pkg::lpg_cmd_t    cmd,
    input  lpg_pkg::lpg_status_t status
);
    import lpg_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        take;

    // output register empty or draining this cycle
    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.advance = 1'b0;
        if (take && op_t'(in_op) == OP_LOAD)
        begin
            cmd.load   = 1'b1;
            state_next = ST_RUN;
        end
        else if (take)
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_RUN:
                begin
                    cmd.advance = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end

        priority if (cmd.advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// File: rtl/lpg_datapath.sv
// line datapath: deltas, error accumulators, position and output payload
module lpg_datapath #(
    parameter int COORD_BITS = 10
) (
    input  logic                           clk,
    input  lpg_pkg::lpg_cmd_t              cmd,
    output lpg_pkg::lpg_status_t           status,
    input  logic [COORD_BITS-1:0]          start_x,
    input  logic [COORD_BITS-1:0]          start_y,
    input  logic [COORD_BITS-1:0]          end_x,
    input  logic [COORD_BITS-1:0]          end_y,
    input  logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    output logic [COORD_BITS-1:0]          point_x,
    output logic [COORD_BITS-1:0]          point_y,
    output logic [lpg_pkg::COLOR_BITS-1:0] point_color,
    output logic                           last_point
);
    import lpg_pkg::*;

    localparam int ACC_BITS = COORD_BITS + 1;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    step_dir_t             step_x_reg, step_x_next;
    step_dir_t             step_y_reg, step_y_next;
    logic [COORD_BITS-1:0] abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0] abs_dy_reg, abs_dy_next;
    logic [COORD_BITS-1:0] major_reg, major_next;
    logic [ACC_BITS-1:0]   err_x_reg, err_x_next;
    logic [ACC_BITS-1:0]   err_y_reg, err_y_next;
    logic [ACC_BITS-1:0]   left_reg, left_next;
    logic [COLOR_BITS-1:0] color_reg;

    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [COLOR_BITS-1:0] pcolor_reg;
    logic                  plast_reg;

    logic [ACC_BITS-1:0]   sum_x, sum_y;
    logic                  last;

    function automatic logic [COORD_BITS-1:0] axis_move(
        input logic [COORD_BITS-1:0] pos,
        input step_dir_t             dir
    );
        logic [COORD_BITS-1:0] res;
        unique case (dir)
            DIR_PLUS:  res = pos + COORD_BITS'(1);
            DIR_MINUS: res = pos - COORD_BITS'(1);
            default:   res = pos;
        endcase
        return res;
    endfunction

    assign last        = left_reg <= ACC_BITS'(1);
    assign status.last = last;

    assign sum_x = err_x_reg + {1'b0, abs_dx_reg};
    assign sum_y = err_y_reg + {1'b0, abs_dy_reg};

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        major_next  = major_reg;
        err_x_next  = err_x_reg;
        err_y_next  = err_y_reg;
        left_next   = left_reg;

        priority if (cmd.load)
        begin
            priority if (end_x > start_x)
            begin
                abs_dx_next = end_x - start_x;
                step_x_next = DIR_PLUS;
            end
            else if (end_x < start_x)
            begin
                abs_dx_next = start_x - end_x;
                step_x_next = DIR_MINUS;
            end
            else
            begin
                abs_dx_next = '0;
                step_x_next = DIR_NONE;
            end
            priority if (end_y > start_y)
            begin
                abs_dy_next = end_y - start_y;
                step_y_next = DIR_PLUS;
            end
            else if (end_y < start_y)
            begin
                abs_dy_next = start_y - end_y;
                step_y_next = DIR_MINUS;
            end
            else
            begin
                abs_dy_next = '0;
                step_y_next = DIR_NONE;
            end
            major_next = (abs_dx_next > abs_dy_next) ? abs_dx_next : abs_dy_next;
            err_x_next = '0;
            err_y_next = '0;
            cur_x_next = start_x;
            cur_y_next = start_y;
            left_next  = {1'b0, major_next} + ACC_BITS'(1);
        end
        else if (cmd.advance)
        begin
            // minor axis steps once its accumulator reaches the major length
            if (sum_x >= {1'b0, major_reg})
            begin
                err_x_next = sum_x - {1'b0, major_reg};
                cur_x_next = axis_move(cur_x_reg, step_x_reg);
            end
            else
            begin
                err_x_next = sum_x;
            end
            if (sum_y >= {1'b0, major_reg})
            begin
                err_y_next = sum_y - {1'b0, major_reg};
                cur_y_next = axis_move(cur_y_reg, step_y_reg);
            end
            else
            begin
                err_y_next = sum_y;
            end
            left_next = last ? '0 : left_reg - ACC_BITS'(1);
        end
        else
        begin
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        abs_dx_reg <= abs_dx_next;
        abs_dy_reg <= abs_dy_next;
        major_reg  <= major_next;
        err_x_reg  <= err_x_next;
        err_y_reg  <= err_y_next;
        left_reg   <= left_next;
        if (cmd.load)
        begin
            color_reg <= pixel_color;
        end
        // output register loads the point before it advances
        if (cmd.advance)
        begin
            px_reg     <= cur_x_reg;
            py_reg     <= cur_y_reg;
            pcolor_reg <= color_reg;
            plast_reg  <= last;
        end
    end

    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_color = pcolor_reg;
    assign last_point  = plast_reg;

endmodule

// File: rtl/line_point_generator_core.sv
// line rasterizer: one load item starts a line, each step item while a line is active yields one pixel
// a step transfer's pixel is registered and shows on the output in the next cycle
// throughput: one item per cycle unless the output stalls, set by the single add, compare and subtract per axis
// a load gives no pixel; a line of major length n yields n+1 pixels, the last flagged
// reset (rst_n low, asynchronous) leaves no line active and the output empty
module line_point_generator_core #(
    parameter int COORD_BITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    lpg_cmd_if.sink    cmd,
    lpg_pixel_if.source pixel
);
    import lpg_pkg::*;

    lpg_cmd_t    dp_cmd;
    lpg_status_t dp_status;

    lpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_op     (cmd.operation),
        .in_ready  (cmd.ready),
        .out_valid (pixel.valid),
        .out_ready (pixel.ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    lpg_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .pixel_color (cmd.pixel_color),
        .point_x     (pixel.point_x),
        .point_y     (pixel.point_y),
        .point_color (pixel.point_color),
        .last_point  (pixel.last_point)
    );

endmodule

// File: rtl/lpg_checker.sv
// port-level checks for the line point generator, bound to the top level
module lpg_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           operation,
    input logic [COORD_BITS-1:0]          start_x,
    input logic [COORD_BITS-1:0]          start_y,
    input logic [COORD_BITS-1:0]          end_x,
    input logic [COORD_BITS-1:0]          end_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [COORD_BITS-1:0]          point_x,
    input logic [COORD_BITS-1:0]          point_y,
    input logic [lpg_pkg::COLOR_BITS-1:0] point_color,
    input logic                           last_point
);
    import lpg_pkg::*;

    logic in_xfer;
    logic is_load;
    logic is_step;

    assign in_xfer = in_valid && in_ready;
    assign is_load = op_t'(operation) == OP_LOAD;
    assign is_step = op_t'(operation) == OP_STEP;

    // a stalled pixel holds
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(point_color) && $stable(last_point))
        else $error("stalled pixel changed");

    // no new item while the output register is full and stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a load never produces a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_load && (!out_valid || out_ready) |=> !out_valid)
        else $error("load produced a pixel");

    // first step after a load emits the start point in the line color
    a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_load ##1 in_xfer && is_step |=> out_valid
            && point_x == $past(start_x, 2) && point_y == $past(start_y, 2)
            && point_color == $past(pixel_color, 2))
        else $error("first pixel is not the start point");

    // a line with equal start and end gives a single flagged pixel
    a_single_point: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && is_load && start_x == end_x && start_y == end_y
            ##1 in_xfer && is_step |=> last_point)
        else $error("single-point line not flagged last");

endmodule

bind line_point_generator_core lpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .operation   (cmd.operation),
    .start_x     (cmd.start_x),
    .start_y     (cmd.start_y),
    .end_x       (cmd.end_x),
    .end_y       (cmd.end_y),
    .pixel_color (cmd.pixel_color),
    .out_valid   (pixel.valid),
    .out_ready   (pixel.ready),
    .point_x     (pixel.point_x),
    .point_y     (pixel.point_y),
    .point_color (pixel.point_color),
    .last_point  (pixel.last_point)
);
